>>> src/scc_pkg.sv
`default_nettype none
package scc_pkg;

  // Record field being parsed
  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_CUR     = 4'd1;
  localparam logic [3:0] PH_WRK     = 4'd2;
  localparam logic [3:0] PH_EPOCH   = 4'd3;
  localparam logic [3:0] PH_SHUF    = 4'd4;
  localparam logic [3:0] PH_COUNT   = 4'd5;
  localparam logic [3:0] PH_INDEX   = 4'd6;
  localparam logic [3:0] PH_TRAILER = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  // Result kinds
  localparam logic [2:0] KIND_POSITION = 3'd0;
  localparam logic [2:0] KIND_EPOCH    = 3'd1;
  localparam logic [2:0] KIND_SHUFFLE  = 3'd2;
  localparam logic [2:0] KIND_COUNT    = 3'd3;
  localparam logic [2:0] KIND_INDEX    = 3'd4;
  localparam logic [2:0] KIND_ACCEPTED = 3'd5;
  localparam logic [2:0] KIND_ERROR    = 3'd6;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MAGIC     = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM  = 2'd3;

  // Input op codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
  // "LTDL" read as a little-endian word
  localparam logic [31:0] MAGIC_WORD = 32'h4C44544C;

endpackage
`default_nettype wire

>>> src/scc_crc_byte.sv
`default_nettype none
module scc_crc_byte
  import scc_pkg::*;
(
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data_byte,
  output logic      [31:0] crc_out
);

  logic [31:0] c [0:8];

  always_comb begin
    c[0] = crc_in ^ {24'd0, data_byte};
    for (int k = 0; k < 8; k++) begin
      c[k + 1] = c[k][0] ? ((c[k] >> 1) ^ CRC_POLY) : (c[k] >> 1);
    end
    crc_out = c[8];
  end

endmodule
`default_nettype wire

>>> src/state_record_crc_checker_core.sv
// Saved-state record checker. Feed the record one byte per item (in_op = 0)
// and close it with an end item (in_op = 1). The block decodes the magic,
// position, worker position, epoch, shuffle byte, index count, the indices
// and the CRC-32 trailer, and returns one item per decoded field (magic
// and worker position excepted) and a verdict: accepted, bad magic,
// checksum mismatch, or truncated when the end item comes before the
// trailer is complete. After a verdict, bytes are dropped until an end
// item re-arms the block. One item is taken every clock cycle while
// in_stall is low. The accepting edge loads the input register; the parse
// logic then loads the result register once the result slot is free.
// A result held by out_stall stalls the input once the input register is
// also full. The byte-wise CRC-32 update in the parse stage sets the cycle
// time.
`default_nettype none
module state_record_crc_checker_core
  import scc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [63:0]      out_value,
  output logic [1:0]       out_error_code
);

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_op_r;
  logic [7:0]  s1_byte_r;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [63:0] field_shift_r, field_shift_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [63:0] indices_left_r, indices_left_nxt;
  logic        verdict_r, verdict_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  logic [1:0]  out_code_r, out_code_nxt;

  logic        out_free, in_take, proc;
  logic        emit;
  logic [2:0]  emit_kind;
  logic [63:0] emit_value;
  logic [1:0]  emit_code;
  logic [63:0] shift_upd;
  logic [31:0] crc_upd;
  logic        field_last;

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign shift_upd = {s1_byte_r, field_shift_r[63:8]};

  scc_crc_byte u_crc (
    .crc_in    (crc_r),
    .data_byte (s1_byte_r),
    .crc_out   (crc_upd)
  );

  always_comb begin
    case (phase_r)
      PH_SHUF:              field_last = 1'b1;
      PH_MAGIC, PH_TRAILER: field_last = (byte_count_r == 3'd3);
      default:              field_last = (byte_count_r == 3'd7);
    endcase
  end

  always_comb begin
    s1_valid_nxt     = in_take ? 1'b1 : (proc ? 1'b0 : s1_valid_r);
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    field_shift_nxt  = field_shift_r;
    crc_nxt          = crc_r;
    indices_left_nxt = indices_left_r;
    verdict_nxt      = verdict_r;
    emit             = 1'b0;
    emit_kind        = KIND_ERROR;
    emit_value       = 64'd0;
    emit_code        = ERR_NONE;

    if (proc) begin
      if (s1_op_r == OP_END) begin
        if (!verdict_r) begin
          emit      = 1'b1;
          emit_kind = KIND_ERROR;
          emit_code = ERR_TRUNCATED;
        end
        // re-arm
        phase_nxt        = PH_MAGIC;
        byte_count_nxt   = 3'd0;
        field_shift_nxt  = 64'd0;
        crc_nxt          = CRC_PRESET;
        indices_left_nxt = 64'd0;
        verdict_nxt      = 1'b0;
      end else if (!verdict_r && phase_r <= PH_TRAILER) begin
        field_shift_nxt = shift_upd;
        if (phase_r != PH_TRAILER) begin
          crc_nxt = crc_upd;
        end
        if (!field_last) begin
          byte_count_nxt = byte_count_r + 3'd1;
        end else begin
          byte_count_nxt  = 3'd0;
          field_shift_nxt = 64'd0;
          case (phase_r)
            PH_MAGIC: begin
              if (shift_upd[63:32] != MAGIC_WORD) begin
                verdict_nxt = 1'b1;
                phase_nxt   = PH_DONE;
                emit        = 1'b1;
                emit_kind   = KIND_ERROR;
                emit_code   = ERR_MAGIC;
              end else begin
                phase_nxt = PH_CUR;
              end
            end
            PH_CUR: begin
              phase_nxt  = PH_WRK;
              emit       = 1'b1;
              emit_kind  = KIND_POSITION;
              emit_value = shift_upd;
            end
            PH_WRK: begin
              phase_nxt = PH_EPOCH;
            end
            PH_EPOCH: begin
              phase_nxt  = PH_SHUF;
              emit       = 1'b1;
              emit_kind  = KIND_EPOCH;
              emit_value = shift_upd;
            end
            PH_SHUF: begin
              phase_nxt  = PH_COUNT;
              emit       = 1'b1;
              emit_kind  = KIND_SHUFFLE;
              emit_value = {63'd0, (s1_byte_r != 8'd0)};
            end
            PH_COUNT: begin
              indices_left_nxt = shift_upd;
              phase_nxt        = (shift_upd == 64'd0) ? PH_TRAILER : PH_INDEX;
              emit             = 1'b1;
              emit_kind        = KIND_COUNT;
              emit_value       = shift_upd;
            end
            PH_INDEX: begin
              indices_left_nxt = indices_left_r - 64'd1;
              if (indices_left_r == 64'd1) begin
                phase_nxt = PH_TRAILER;
              end
              emit       = 1'b1;
              emit_kind  = KIND_INDEX;
              emit_value = shift_upd;
            end
            default: begin
              verdict_nxt = 1'b1;
              phase_nxt   = PH_DONE;
              emit        = 1'b1;
              if (shift_upd[63:32] == ~crc_r) begin
                emit_kind = KIND_ACCEPTED;
              end else begin
                emit_kind = KIND_ERROR;
                emit_code = ERR_CHECKSUM;
              end
            end
          endcase
        end
      end
    end

    // hold a stalled result; load a new one only when the slot frees up
    out_valid_nxt = out_free ? emit : out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_code_nxt  = out_code_r;
    if (out_free && emit) begin
      out_kind_nxt  = emit_kind;
      out_value_nxt = emit_value;
      out_code_nxt  = emit_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      phase_r        <= PH_MAGIC;
      byte_count_r   <= 3'd0;
      field_shift_r  <= 64'd0;
      crc_r          <= CRC_PRESET;
      indices_left_r <= 64'd0;
      verdict_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      field_shift_r  <= field_shift_nxt;
      crc_r          <= crc_nxt;
      indices_left_r <= indices_left_nxt;
      verdict_r      <= verdict_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_op;
      s1_byte_r <= in_data_byte;
    end
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_code_r  <= out_code_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_value      = out_value_r;
  assign out_error_code = out_code_r;

endmodule
`default_nettype wire

>>> src/scc_chk.sv
`default_nettype none
module scc_chk
  import scc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_kind,
  input wire logic [63:0] out_value,
  input wire logic [1:0]  out_error_code
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_error_code))
    else $error("stalled result changed");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_ERROR) |-> out_error_code == ERR_NONE)
    else $error("error code on a non-error result");

  a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ERROR) |-> out_error_code != ERR_NONE)
    else $error("error result without a code");

  a_verdict_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ERROR || out_kind == KIND_ACCEPTED)
      |-> out_value == 64'd0)
    else $error("verdict carries a value");

  a_shuffle_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SHUFFLE) |-> out_value[63:1] == 63'd0)
    else $error("shuffle flag wider than one bit");

endmodule

bind state_record_crc_checker_core scc_chk u_scc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_value      (out_value),
  .out_error_code (out_error_code)
);
`default_nettype wire

>>> dv/state_record_crc_checker_core_tb.sv
`timescale 1ns / 100ps
module state_record_crc_checker_core_tb;
  import scc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 450;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [1:0]  code;
  } field_result_t;

  typedef enum logic [2:0] {
    FLAW_NONE, FLAW_CRC, FLAW_MAGIC, FLAW_CUT, FLAW_COUNT
  } record_flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_DATA;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [63:0] out_value;
  logic [1:0]  out_error_code;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          err_count = 0;
  int          live_items = 0;
  int          quiet_cycles = 0;

  // Expected decoded fields and verdicts, oldest first
  field_result_t pending_fields[$];

  // Predicted parser state
  logic [3:0]  fld_phase;
  logic [2:0]  fld_bytes;
  logic [63:0] fld_shift;
  logic [31:0] crc_acc;
  logic [63:0] idx_left;
  logic        verdict_out;

  state_record_crc_checker_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_error_code(out_error_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic rearm_parser();
    fld_phase = PH_MAGIC;
    fld_bytes = '0;
    fld_shift = '0;
    crc_acc = CRC_PRESET;
    idx_left = '0;
    verdict_out = 1'b0;
  endtask

  task automatic push_field(input logic [2:0] kind, input logic [63:0] value,
                            input logic [1:0] code);
    field_result_t f;
    f.kind = kind;
    f.value = value;
    f.code = code;
    pending_fields.insert(pending_fields.size(), f);
  endtask

  // Advance the predicted parser by one accepted item
  task automatic parse_record_byte(input logic op, input logic [7:0] b);
    logic [3:0]  len;
    logic [63:0] val;
    if (op == OP_END) begin
      if (!verdict_out) push_field(KIND_ERROR, '0, ERR_TRUNCATED);
      rearm_parser();
      return;
    end
    if (verdict_out || fld_phase > PH_TRAILER) return;
    fld_shift = {b, fld_shift[63:8]};
    if (fld_phase != PH_TRAILER) crc_acc = crc_next(crc_acc, b);
    if (fld_phase == PH_SHUF) len = 4'd1;
    else if (fld_phase == PH_MAGIC || fld_phase == PH_TRAILER) len = 4'd4;
    else len = 4'd8;
    if ({1'b0, fld_bytes} != len - 4'd1) begin
      fld_bytes = fld_bytes + 3'd1;
      return;
    end
    fld_bytes = '0;
    if (len == 4'd8) val = fld_shift;
    else if (len == 4'd4) val = fld_shift >> 32;
    else val = fld_shift >> 56;
    fld_shift = '0;
    case (fld_phase)
      PH_MAGIC: begin
        if (val[31:0] != MAGIC_WORD) begin
          verdict_out = 1'b1;
          fld_phase = PH_DONE;
          push_field(KIND_ERROR, '0, ERR_MAGIC);
        end else begin
          fld_phase = PH_CUR;
        end
      end
      PH_CUR: begin
        fld_phase = PH_WRK;
        push_field(KIND_POSITION, val, ERR_NONE);
      end
      PH_WRK: fld_phase = PH_EPOCH;
      PH_EPOCH: begin
        fld_phase = PH_SHUF;
        push_field(KIND_EPOCH, val, ERR_NONE);
      end
      PH_SHUF: begin
        fld_phase = PH_COUNT;
        push_field(KIND_SHUFFLE, (val != 0) ? 64'd1 : 64'd0, ERR_NONE);
      end
      PH_COUNT: begin
        idx_left = val;
        fld_phase = (val == 0) ? PH_TRAILER : PH_INDEX;
        push_field(KIND_COUNT, val, ERR_NONE);
      end
      PH_INDEX: begin
        idx_left = idx_left - 64'd1;
        if (idx_left == 0) fld_phase = PH_TRAILER;
        push_field(KIND_INDEX, val, ERR_NONE);
      end
      default: begin
        verdict_out = 1'b1;
        fld_phase = PH_DONE;
        if (val[31:0] == (crc_acc ^ CRC_PRESET)) push_field(KIND_ACCEPTED, '0, ERR_NONE);
        else push_field(KIND_ERROR, '0, ERR_CHECKSUM);
      end
    endcase
  endtask

  // Hold the item until accepted; valid is only lowered inside the idle gap
  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    live_items++;
    parse_record_byte(op, b);
  endtask

  task automatic send_word(input logic [63:0] w);
    for (int k = 0; k < 8; k++) send_item(OP_DATA, w[8*k +: 8]);
  endtask

  task automatic send_record(input int n_idx, input record_flaw_t flaw);
    logic [7:0]  body[$];
    logic [63:0] w;
    logic [31:0] crc;
    int          cut;
    for (int k = 0; k < 4; k++) body.insert(body.size(), MAGIC_WORD[8*k +: 8]);
    for (int f = 0; f < 3; f++) begin
      w = rand_word();
      for (int k = 0; k < 8; k++) body.insert(body.size(), w[8*k +: 8]);
    end
    body.insert(body.size(), ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)));
    // An oversized count leaves the trailer parsed as index bytes
    w = (flaw == FLAW_COUNT) ? ({$urandom, $urandom} | 64'h0000_0100_0000_0000)
                             : 64'(n_idx);
    for (int k = 0; k < 8; k++) body.insert(body.size(), w[8*k +: 8]);
    for (int i = 0; i < n_idx; i++) begin
      w = rand_word();
      for (int k = 0; k < 8; k++) body.insert(body.size(), w[8*k +: 8]);
    end
    crc = CRC_PRESET;
    foreach (body[i]) crc = crc_next(crc, body[i]);
    crc = crc ^ CRC_PRESET;
    for (int k = 0; k < 4; k++) body.insert(body.size(), crc[8*k +: 8]);
    case (flaw)
      FLAW_CRC: begin
        cut = $urandom_range(body.size() - 1);
        body[cut] = body[cut] ^ (8'd1 << $urandom_range(7));
      end
      FLAW_MAGIC: begin
        cut = $urandom_range(3);
        body[cut] = body[cut] ^ (8'd1 << $urandom_range(7));
      end
      FLAW_CUT: begin
        cut = $urandom_range(body.size() - 1, 1);
        while (body.size() > cut) void'(body.pop_back());
      end
      default: ;
    endcase
    foreach (body[i]) send_item(OP_DATA, body[i]);
    // Trailing bytes after a verdict must be dropped
    if (flaw != FLAW_CUT) begin
      repeat ($urandom_range(2)) send_item(OP_DATA, 8'($urandom_range(255)));
    end
    send_item(OP_END, 8'($urandom_range(255)));
    if ($urandom_range(15) == 0) send_item(OP_END, 8'($urandom_range(255)));
  endtask

  task automatic test_end_items();
    send_item(OP_END, 8'h00);
    send_item(OP_END, 8'hFF);
  endtask

  task automatic test_bad_magic();
    send_item(OP_DATA, "L");
    send_item(OP_DATA, "T");
    send_item(OP_DATA, "D");
    send_item(OP_DATA, "M");
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, "L");
    send_item(OP_END, 8'h00);
    repeat (4) send_item(OP_DATA, 8'hFF);
    send_item(OP_END, 8'hFF);
  endtask

  task automatic test_truncated_magic();
    send_item(OP_DATA, "L");
    send_item(OP_DATA, "T");
    send_item(OP_END, 8'h00);
    send_item(OP_DATA, 8'h00);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_random_records(input int idle_pct, input int stall_chance);
    int goal;
    int sel;
    send_idle_pct = idle_pct;
    stall_pct = stall_chance;
    goal = live_items + PHASE_ITEMS;
    while (live_items < goal) begin
      sel = $urandom_range(99);
      if (sel < 60) send_record($urandom_range(4), FLAW_NONE);
      else if (sel < 72) send_record($urandom_range(4), FLAW_CRC);
      else if (sel < 80) send_record($urandom_range(2), FLAW_MAGIC);
      else if (sel < 90) send_record($urandom_range(4), FLAW_CUT);
      else if (sel < 95) send_record($urandom_range(3), FLAW_COUNT);
      else begin
        repeat ($urandom_range(6, 1)) begin
          send_item(($urandom_range(7) == 0) ? OP_END : OP_DATA, 8'($urandom_range(255)));
        end
        send_item(OP_END, 8'($urandom_range(255)));
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    field_result_t exp_f;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_fields.size() == 0) begin
        report_error($sformatf("unexpected item kind %0d value %0h code %0d",
                               out_kind, out_value, out_error_code));
      end else begin
        exp_f = pending_fields.pop_front();
        if (out_kind !== exp_f.kind)
          report_error($sformatf("kind expected %0d got %0d", exp_f.kind, out_kind));
        if (out_value !== exp_f.value)
          report_error($sformatf("value expected %0h got %0h (kind %0d)",
                                 exp_f.value, out_value, exp_f.kind));
        if (out_error_code !== exp_f.code)
          report_error($sformatf("error code expected %0d got %0d",
                                 exp_f.code, out_error_code));
      end
    end
  end

  // End the run when no item moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rearm_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_end_items();
    test_bad_magic();
    test_truncated_magic();
    test_random_records(0, 0);
    test_random_records(85, 0);
    test_random_records(0, 85);
    test_random_records(17, 17);
    in_valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
src/scc_pkg.sv
src/scc_crc_byte.sv
src/state_record_crc_checker_core.sv
src/scc_chk.sv
dv/state_record_crc_checker_core_tb.sv
